[rtl/fpub_pkg.sv]
// Shared types and constants of the beta-chain leapfrog stepper.
`timescale 1ns / 1ps
package fpub_pkg;

  localparam int MAX_MASSES_DEF  = 1024;
  localparam int VALUE_WIDTH_DEF = 32;
  localparam int CMDQ_DEPTH      = 2;
  localparam int RESQ_DEPTH      = 2;

  localparam logic [30:0] BETA_RESET = 31'd80530637;
  localparam logic [28:0] DT_RESET   = 29'd2684355;
  localparam logic [10:0] LEN_RESET  = 11'd1024;

  // configuration register indexes
  localparam logic [1:0] CFG_BETA = 2'd0;
  localparam logic [1:0] CFG_DT   = 2'd1;
  localparam logic [1:0] CFG_LEN  = 2'd2;

  typedef enum logic [1:0] {
    KIND_LOAD  = 2'd0,
    KIND_START = 2'd1,
    KIND_STEP  = 2'd2,
    KIND_READ  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_SAT   = 2'd2
  } status_t;

  typedef struct packed {
    kind_t       kind;
    logic        bad;
    logic [9:0]  idx;
    logic [31:0] value;
  } cmd_t;

  typedef struct packed {
    logic [9:0]  idx;
    logic [31:0] pos;
    logic [31:0] vel;
    status_t     status;
  } res_t;

  typedef enum logic [4:0] {
    S_CLEAR,
    S_IDLE,
    S_READ_WAIT,
    S_START_V,
    S_P_RD,
    S_P_MUL,
    S_P_WR,
    S_W_RD0,
    S_W_RD1,
    S_W_LD1,
    S_K_RD,
    S_K_DIF,
    S_K_M1,
    S_K_M2,
    S_K_M3,
    S_K_M4,
    S_K_CD,
    S_K_M5,
    S_K_ACC,
    S_K_M6,
    S_K_WR,
    S_RESULT
  } eng_state_t;

endpackage

[rtl/fpub_fifo.sv]
// Small register FIFO used for the command and result queues.
`timescale 1ns / 1ps
module fpub_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wptr;
  logic [PW-1:0]    rptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == PW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= (rptr == PW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[rtl/fpub_front.sv]
// Command front end: decodes and range-checks commands into the command queue.
`timescale 1ns / 1ps
module fpub_front #(
  parameter int MAX_MASSES = fpub_pkg::MAX_MASSES_DEF,
  localparam int NW = $clog2(MAX_MASSES) + 1
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  logic [1:0]     kind,
  input  logic [9:0]     mass_index,
  input  logic [31:0]    load_value,
  input  logic [NW-1:0]  n,
  output logic           full,
  output logic           cmd_valid,
  output fpub_pkg::cmd_t cmd,
  input  logic           cmd_pop
);

  localparam int CMDW = $bits(fpub_pkg::cmd_t);

  fpub_pkg::cmd_t  dec;
  logic [CMDW-1:0] q_dout;
  logic            q_empty;

  always_comb begin
    dec.kind  = fpub_pkg::kind_t'(kind);
    dec.idx   = mass_index;
    dec.value = load_value;
    dec.bad   = (dec.kind inside {fpub_pkg::KIND_LOAD, fpub_pkg::KIND_READ}) &&
                (32'(mass_index) >= 32'(n));
  end

  fpub_fifo #(
    .WIDTH(CMDW),
    .DEPTH(fpub_pkg::CMDQ_DEPTH)
  ) u_cmdq (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .din  (dec),
    .full (full),
    .pop  (cmd_pop),
    .dout (q_dout),
    .empty(q_empty)
  );

  assign cmd       = fpub_pkg::cmd_t'(q_dout);
  assign cmd_valid = !q_empty;

endmodule

[rtl/fpub_engine.sv]
// Back end: position/velocity stores and the sequenced leapfrog datapath.
`timescale 1ns / 1ps
module fpub_engine #(
  parameter int MAX_MASSES  = fpub_pkg::MAX_MASSES_DEF,
  parameter int VALUE_WIDTH = fpub_pkg::VALUE_WIDTH_DEF,
  localparam int NW = $clog2(MAX_MASSES) + 1
) (
  input  logic           clk,
  input  logic           rst,
  input  logic [30:0]    beta,
  input  logic [28:0]    dt,
  input  logic [NW-1:0]  n,
  input  logic           cmd_valid,
  input  fpub_pkg::cmd_t cmd,
  output logic           cmd_pop,
  input  logic           res_full,
  output logic           res_push,
  output fpub_pkg::res_t res_data,
  output logic           clearing
);

  localparam int W    = (VALUE_WIDTH > 32) ? 32 : VALUE_WIDTH;
  localparam int IDXW = $clog2(MAX_MASSES);
  localparam logic signed [67:0] VMAX68 = (68'sd1 <<< (W - 1)) - 68'sd1;
  localparam logic signed [67:0] VMIN68 = -VMAX68 - 68'sd1;
  localparam logic [W-1:0] VMAXV = VMAX68[W-1:0];
  localparam logic [W-1:0] VMINV = VMIN68[W-1:0];

  // {clamped flag, value}
  function automatic logic [W:0] clampw(input logic signed [67:0] x);
    logic [W:0] r;
    if (x > VMAX68) begin
      r = {1'b1, VMAXV};
    end else if (x < VMIN68) begin
      r = {1'b1, VMINV};
    end else begin
      r = {1'b0, x[W-1:0]};
    end
    return r;
  endfunction

  logic signed [W-1:0] pos_mem [MAX_MASSES];
  logic signed [W-1:0] vel_mem [MAX_MASSES];

  fpub_pkg::eng_state_t state, state_next;

  logic                p_we, v_we;
  logic [IDXW-1:0]     p_wa, v_wa, p_ra, v_ra;
  logic signed [W-1:0] p_wd, v_wd;
  logic signed [W-1:0] pos_rd, vel_rd;

  logic [IDXW-1:0]     ccnt;
  logic [IDXW-1:0]     j;
  logic                half;
  logic                walk;
  logic                sat_flag;
  logic                sat_hit;
  logic                flag_clr;
  fpub_pkg::res_t      res;

  logic signed [W-1:0] w0, w1, w2, vcur, pcur;
  logic signed [W-1:0] d0, d1, t0, c0, c1, lin, cd, bq, acc, kreg;

  logic [NW-1:0]       nm1, nm2;
  logic                j_last;
  logic [IDXW-1:0]     cmd_addr;

  logic signed [32:0]  ma, mb;
  logic signed [65:0]  prod;
  logic signed [67:0]  p68, rnd;
  logic                sh29;
  logic [W:0]          c_mul, c_d0, c_d1, c_lin, c_cd, c_a, c_v, c_p, c_ld;

  assign nm1      = n - 1'b1;
  assign nm2      = n - NW'(2);
  assign j_last   = ({1'b0, j} == nm2);
  assign cmd_addr = IDXW'(cmd.idx);
  assign clearing = (state == fpub_pkg::S_CLEAR);

  // shared multiplier with rounding and saturation
  always_comb begin
    ma = 33'(d0);
    mb = 33'(d0);
    case (state)
      fpub_pkg::S_K_M2: begin ma = 33'(t0); mb = 33'(d0); end
      fpub_pkg::S_K_M3: begin ma = 33'(d1); mb = 33'(d1); end
      fpub_pkg::S_K_M4: begin ma = 33'(t0); mb = 33'(d1); end
      fpub_pkg::S_K_M5: begin ma = signed'({2'b00, beta}); mb = 33'(cd); end
      fpub_pkg::S_K_M6: begin ma = 33'(acc); mb = signed'({4'b0000, dt}); end
      fpub_pkg::S_P_MUL: begin ma = 33'(vel_rd); mb = signed'({4'b0000, dt}); end
      default: begin ma = 33'(d0); mb = 33'(d0); end
    endcase
  end

  assign prod  = ma * mb;
  assign p68   = 68'(prod);
  assign sh29  = (state == fpub_pkg::S_K_M6) && half;
  assign rnd   = sh29 ? ((p68 + (68'sd1 <<< 28)) >>> 29) : ((p68 + (68'sd1 <<< 27)) >>> 28);
  assign c_mul = clampw(rnd);

  assign c_d0  = clampw(68'(w1) - 68'(w0));
  assign c_d1  = clampw(68'(pos_rd) - 68'(w1));
  assign c_lin = clampw(68'(d1) - 68'(d0));
  assign c_cd  = clampw(68'(c1) - 68'(c0));
  assign c_a   = clampw(68'(lin) + 68'(bq));
  assign c_v   = clampw(68'(vcur) + 68'(kreg));
  assign c_p   = clampw(68'(pcur) + 68'(kreg));
  assign c_ld  = clampw(68'(signed'(cmd.value)));

  // stores
  always_ff @(posedge clk) begin
    if (p_we) begin
      pos_mem[p_wa] <= p_wd;
    end
    pos_rd <= pos_mem[p_ra];
  end

  always_ff @(posedge clk) begin
    if (v_we) begin
      vel_mem[v_wa] <= v_wd;
    end
    vel_rd <= vel_mem[v_ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fpub_pkg::S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd_pop    = 1'b0;
    res_push   = 1'b0;
    p_we       = 1'b0;
    v_we       = 1'b0;
    p_wa       = j;
    v_wa       = j;
    p_wd       = '0;
    v_wd       = '0;
    p_ra       = j;
    v_ra       = j;
    sat_hit    = 1'b0;
    flag_clr   = 1'b0;
    case (state)
      fpub_pkg::S_CLEAR: begin
        p_we = 1'b1;
        v_we = 1'b1;
        p_wa = ccnt;
        v_wa = ccnt;
        if (ccnt == IDXW'(MAX_MASSES - 1)) begin
          state_next = fpub_pkg::S_IDLE;
        end
      end
      fpub_pkg::S_IDLE: begin
        if (cmd_valid) begin
          cmd_pop = 1'b1;
          if (cmd.bad) begin
            state_next = fpub_pkg::S_RESULT;
          end else begin
            case (cmd.kind)
              fpub_pkg::KIND_LOAD: begin
                p_we       = 1'b1;
                v_we       = 1'b1;
                p_wa       = cmd_addr;
                v_wa       = cmd_addr;
                p_wd       = c_ld[W-1:0];
                sat_hit    = c_ld[W];
                state_next = fpub_pkg::S_RESULT;
              end
              fpub_pkg::KIND_READ: begin
                p_ra       = cmd_addr;
                v_ra       = cmd_addr;
                state_next = fpub_pkg::S_READ_WAIT;
              end
              fpub_pkg::KIND_START: begin
                flag_clr   = 1'b1;
                v_we       = 1'b1;
                v_wa       = '0;
                state_next = fpub_pkg::S_START_V;
              end
              fpub_pkg::KIND_STEP: begin
                flag_clr   = 1'b1;
                state_next = fpub_pkg::S_P_RD;
              end
              default: state_next = fpub_pkg::S_RESULT;
            endcase
          end
        end
      end
      fpub_pkg::S_READ_WAIT: state_next = fpub_pkg::S_RESULT;
      fpub_pkg::S_START_V: begin
        v_we       = 1'b1;
        v_wa       = nm1[IDXW-1:0];
        state_next = fpub_pkg::S_W_RD0;
      end
      fpub_pkg::S_P_RD: state_next = fpub_pkg::S_P_MUL;
      fpub_pkg::S_P_MUL: begin
        sat_hit    = c_mul[W];
        state_next = fpub_pkg::S_P_WR;
      end
      fpub_pkg::S_P_WR: begin
        p_we       = 1'b1;
        p_wd       = c_p[W-1:0];
        sat_hit    = c_p[W];
        state_next = j_last ? fpub_pkg::S_W_RD0 : fpub_pkg::S_P_RD;
      end
      fpub_pkg::S_W_RD0: begin
        p_ra       = '0;
        state_next = fpub_pkg::S_W_RD1;
      end
      fpub_pkg::S_W_RD1: begin
        p_ra       = IDXW'(1);
        state_next = fpub_pkg::S_W_LD1;
      end
      fpub_pkg::S_W_LD1: state_next = fpub_pkg::S_K_RD;
      fpub_pkg::S_K_RD: begin
        p_ra       = j + 1'b1;
        state_next = fpub_pkg::S_K_DIF;
      end
      fpub_pkg::S_K_DIF: begin
        sat_hit    = c_d0[W] | c_d1[W];
        state_next = fpub_pkg::S_K_M1;
      end
      fpub_pkg::S_K_M1: begin sat_hit = c_mul[W]; state_next = fpub_pkg::S_K_M2; end
      fpub_pkg::S_K_M2: begin sat_hit = c_mul[W]; state_next = fpub_pkg::S_K_M3; end
      fpub_pkg::S_K_M3: begin sat_hit = c_mul[W]; state_next = fpub_pkg::S_K_M4; end
      fpub_pkg::S_K_M4: begin sat_hit = c_mul[W]; state_next = fpub_pkg::S_K_CD; end
      fpub_pkg::S_K_CD: begin
        sat_hit    = c_lin[W] | c_cd[W];
        state_next = fpub_pkg::S_K_M5;
      end
      fpub_pkg::S_K_M5: begin sat_hit = c_mul[W]; state_next = fpub_pkg::S_K_ACC; end
      fpub_pkg::S_K_ACC: begin sat_hit = c_a[W]; state_next = fpub_pkg::S_K_M6; end
      fpub_pkg::S_K_M6: begin sat_hit = c_mul[W]; state_next = fpub_pkg::S_K_WR; end
      fpub_pkg::S_K_WR: begin
        v_we       = 1'b1;
        v_wd       = half ? kreg : c_v[W-1:0];
        sat_hit    = !half && c_v[W];
        state_next = j_last ? fpub_pkg::S_RESULT : fpub_pkg::S_K_RD;
      end
      fpub_pkg::S_RESULT: begin
        res_push = !res_full;
        if (!res_full) begin
          state_next = fpub_pkg::S_IDLE;
        end
      end
      default: state_next = fpub_pkg::S_IDLE;
    endcase
  end

  // start and step report the flag as it stands at the end of the walk
  always_comb begin
    res_data = res;
    if (walk) begin
      res_data.status = sat_flag ? fpub_pkg::ST_SAT : fpub_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sat_flag <= 1'b0;
      ccnt     <= '0;
    end else begin
      if (flag_clr) begin
        sat_flag <= 1'b0;
      end else if (sat_hit) begin
        sat_flag <= 1'b1;
      end
      if (state == fpub_pkg::S_CLEAR) begin
        ccnt <= ccnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      fpub_pkg::S_IDLE: begin
        half       <= (cmd.kind == fpub_pkg::KIND_START);
        walk       <= (cmd.kind == fpub_pkg::KIND_START) || (cmd.kind == fpub_pkg::KIND_STEP);
        j          <= IDXW'(1);
        res.idx    <= '0;
        res.pos    <= '0;
        res.vel    <= '0;
        res.status <= fpub_pkg::ST_OK;
        if (cmd.kind == fpub_pkg::KIND_LOAD || cmd.kind == fpub_pkg::KIND_READ) begin
          res.idx <= cmd.idx;
        end
        if (cmd.bad) begin
          res.status <= fpub_pkg::ST_RANGE;
        end else if (cmd.kind == fpub_pkg::KIND_LOAD) begin
          res.pos    <= 32'(signed'(c_ld[W-1:0]));
          res.status <= c_ld[W] ? fpub_pkg::ST_SAT : fpub_pkg::ST_OK;
        end
      end
      fpub_pkg::S_READ_WAIT: begin
        res.pos    <= 32'(pos_rd);
        res.vel    <= 32'(vel_rd);
        res.status <= sat_flag ? fpub_pkg::ST_SAT : fpub_pkg::ST_OK;
      end
      fpub_pkg::S_P_MUL: begin
        pcur <= pos_rd;
        kreg <= c_mul[W-1:0];
      end
      fpub_pkg::S_P_WR: begin
        if (!j_last) begin
          j <= j + 1'b1;
        end
      end
      fpub_pkg::S_W_RD1: w0 <= pos_rd;
      fpub_pkg::S_W_LD1: begin
        w1 <= pos_rd;
        j  <= IDXW'(1);
      end
      fpub_pkg::S_K_DIF: begin
        w2   <= pos_rd;
        vcur <= vel_rd;
        d0   <= c_d0[W-1:0];
        d1   <= c_d1[W-1:0];
      end
      fpub_pkg::S_K_M1: t0 <= c_mul[W-1:0];
      fpub_pkg::S_K_M2: c0 <= c_mul[W-1:0];
      fpub_pkg::S_K_M3: t0 <= c_mul[W-1:0];
      fpub_pkg::S_K_M4: c1 <= c_mul[W-1:0];
      fpub_pkg::S_K_CD: begin
        lin <= c_lin[W-1:0];
        cd  <= c_cd[W-1:0];
      end
      fpub_pkg::S_K_M5: bq <= c_mul[W-1:0];
      fpub_pkg::S_K_ACC: acc <= c_a[W-1:0];
      fpub_pkg::S_K_M6: kreg <= c_mul[W-1:0];
      fpub_pkg::S_K_WR: begin
        w0 <= w1;
        w1 <= w2;
        if (!j_last) begin
          j <= j + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  a_no_pop_in_clear: assert property (@(posedge clk) disable iff (rst)
    (state == fpub_pkg::S_CLEAR) |-> !cmd_pop)
    else $error("command taken during store clearing");

  a_pop_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    cmd_pop |=> (state != fpub_pkg::S_IDLE))
    else $error("engine stayed idle after taking a command");

  a_range_zero: assert property (@(posedge clk) disable iff (rst)
    (res_push && res_data.status == fpub_pkg::ST_RANGE) |->
    (res_data.pos == '0 && res_data.vel == '0))
    else $error("out of range result carries data");

  a_walk_bound: assert property (@(posedge clk) disable iff (rst)
    (state == fpub_pkg::S_K_WR) |-> (32'(j) + 32'd1 < 32'(n)))
    else $error("walk index past the last interior mass");

endmodule

[rtl/nonlinear_chain_leapfrog_step.sv]
// Top level of the beta-chain leapfrog stepper: config registers, queues, engine.
`timescale 1ns / 1ps
// Usage:
//  Commands enter through a queue interface: a transaction is taken when push is
//  high and full is low. kind selects load, start half kick, step or read.
//  Results leave through a queue interface: while empty is low the oldest
//  result sits on echo_index/position_out/velocity_out/status, and pop with
//  empty low takes it. Every command yields exactly one result.
//  Configuration (beta_gain, time_step, chain_length at index 0..2) is written on
//  cfg_valid/cfg_ready; cfg_ready is always high. Write only while idle.
//  Commands are sequenced through the single shared multiplier in the engine.
//  One command is worked on at a time; a two-entry command queue lets the
//  sender run ahead, and a two-entry result queue lets the engine finish while
//  the receiver stalls. When the result queue is full the engine holds its
//  finished result and stops.
//  Reset: after rst the engine sweeps both stores to zero, with full held
//  high; config writes are still taken during the sweep.
module nonlinear_chain_leapfrog_step #(
  parameter int MAX_MASSES  = fpub_pkg::MAX_MASSES_DEF,
  parameter int VALUE_WIDTH = fpub_pkg::VALUE_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  kind,
  input  logic [9:0]  mass_index,
  input  logic [31:0] load_value,
  output logic        empty,
  input  logic        pop,
  output logic [9:0]  echo_index,
  output logic [31:0] position_out,
  output logic [31:0] velocity_out,
  output logic [1:0]  status,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int NW   = $clog2(MAX_MASSES) + 1;
  localparam int RESW = $bits(fpub_pkg::res_t);

  logic [30:0]    beta_gain;
  logic [28:0]    time_step;
  logic [10:0]    chain_length;
  logic [NW-1:0]  n;

  logic           front_full;
  logic           clearing;
  logic           cmd_valid;
  logic           cmd_pop;
  fpub_pkg::cmd_t cmd;
  logic           res_full;
  logic           res_push;
  fpub_pkg::res_t res_data;
  logic [RESW-1:0] res_q;
  fpub_pkg::res_t res_out;

  assign cfg_ready = 1'b1;

  // config registers; index 3 has no register
  always_ff @(posedge clk) begin
    if (rst) begin
      beta_gain    <= fpub_pkg::BETA_RESET;
      time_step    <= fpub_pkg::DT_RESET;
      chain_length <= fpub_pkg::LEN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        fpub_pkg::CFG_BETA: beta_gain    <= cfg_data[30:0];
        fpub_pkg::CFG_DT:   time_step    <= cfg_data[28:0];
        fpub_pkg::CFG_LEN:  chain_length <= cfg_data[10:0];
        default: begin
        end
      endcase
    end
  end

  // chain length in use, clamped to [3, MAX_MASSES]
  always_comb begin
    if (chain_length < 11'd3) begin
      n = NW'(3);
    end else if (32'(chain_length) > 32'(MAX_MASSES)) begin
      n = NW'(MAX_MASSES);
    end else begin
      n = NW'(chain_length);
    end
  end

  // no commands while the stores are being cleared
  assign full = front_full || clearing;

  fpub_front #(
    .MAX_MASSES(MAX_MASSES)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push && !full),
    .kind      (kind),
    .mass_index(mass_index),
    .load_value(load_value),
    .n         (n),
    .full      (front_full),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  fpub_engine #(
    .MAX_MASSES (MAX_MASSES),
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_engine (
    .clk      (clk),
    .rst      (rst),
    .beta     (beta_gain),
    .dt       (time_step),
    .n        (n),
    .cmd_valid(cmd_valid),
    .cmd      (cmd),
    .cmd_pop  (cmd_pop),
    .res_full (res_full),
    .res_push (res_push),
    .res_data (res_data),
    .clearing (clearing)
  );

  // result queue decouples the engine from a stalling receiver
  fpub_fifo #(
    .WIDTH(RESW),
    .DEPTH(fpub_pkg::RESQ_DEPTH)
  ) u_resq (
    .clk  (clk),
    .rst  (rst),
    .push (res_push),
    .din  (res_data),
    .full (res_full),
    .pop  (pop),
    .dout (res_q),
    .empty(empty)
  );

  assign res_out      = fpub_pkg::res_t'(res_q);
  assign echo_index   = res_out.idx;
  assign position_out = res_out.pos;
  assign velocity_out = res_out.vel;
  assign status       = res_out.status;

endmodule
